// ===== hw/rtl/rrhc_pkg.sv =====
`default_nettype none

package rrhc_pkg;

  // Ring geometry and frame limits
  localparam int unsigned PageBytes = 256;
  localparam int unsigned HdrBytes  = 4;
  localparam int unsigned FcsBytes  = 4;
  localparam int unsigned FrameMin  = 60;
  localparam int unsigned FrameMax  = 1514;

  localparam int unsigned SpaceW = 17;
  localparam int unsigned PageW  = 8;
  localparam int unsigned WrapW  = 9;
  localparam int unsigned DlenW  = 11;

  localparam logic [7:0] StatusIntact = 8'h01;

  // Space on the ring that a legal frame may take
  localparam logic [SpaceW-1:0] SpaceMin = SpaceW'(HdrBytes + FrameMin + FcsBytes);
  localparam logic [SpaceW-1:0] SpaceMax = SpaceW'(HdrBytes + FrameMax + FcsBytes);
  localparam logic [SpaceW-1:0] SpaceOvh = SpaceW'(HdrBytes + FcsBytes);
  localparam logic [SpaceW-1:0] FcsAdd   = SpaceW'(FcsBytes);
  localparam logic [SpaceW-1:0] PageRnd  = SpaceW'(PageBytes - 1);

  // Verdict codes
  localparam logic [1:0] VerdictOk      = 2'd0;
  localparam logic [1:0] VerdictBadNext = 2'd1;
  localparam logic [1:0] VerdictBadCnt  = 2'd2;
  localparam logic [1:0] VerdictRxErr   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CfgRingStart = 2'd0;
  localparam logic [1:0] CfgRingStop  = 2'd1;
  localparam logic [1:0] CfgCountFcs  = 2'd2;

  localparam logic [7:0] RingStartRst = 8'd64;
  localparam logic [7:0] RingStopRst  = 8'd128;

  typedef struct packed {
    logic [7:0]  rx_status;
    logic [7:0]  next_page;
    logic [15:0] byte_count;
    logic [7:0]  read_page;
  } req_t;

  typedef struct packed {
    logic [1:0]       verdict;
    logic [DlenW-1:0] data_length;
    logic [7:0]       boundary_page;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rx_ring_header_checker.sv =====
`default_nettype none

// Checks one receive-ring packet header per request against the configured ring.
// A request is taken when start is high and busy is low; its result is shown
// for exactly one cycle with res_valid_o high, and the receiver cannot stall it.
// A request failing the next-pointer or count check gives its result in the done
// state straight after the check state. Otherwise the page advance is wrapped into
// the ring by one subtraction of the ring size per cycle, and the result comes once
// the wrap is done, after k subtractions (0 to 261, set by the ring size). busy
// drops the cycle after the result. Configuration writes are always ready and must
// only be issued while busy is low.
module rx_ring_header_checker (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire rrhc_pkg::req_t req_i,
  output logic                res_valid_o,
  output rrhc_pkg::res_t      res_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [7:0]     cfg_data_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StWrap  = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0] state_q, state_d;

  logic [7:0] ring_start_q, ring_stop_q;
  logic       count_fcs_q;

  rrhc_pkg::req_t                  req_q;
  logic [rrhc_pkg::SpaceW-1:0]     space_q, space_d;
  logic [1:0]                      verdict_q, verdict_d;
  logic [rrhc_pkg::DlenW-1:0]      dlen_q, dlen_d;

  logic                            next_bad, count_bad;
  logic [rrhc_pkg::SpaceW-1:0]     rnd_space;
  logic [rrhc_pkg::WrapW-1:0]      adv_page;
  logic [rrhc_pkg::SpaceW-1:0]     dlen_full;
  logic                            wrap_load, wrap_done;
  logic [rrhc_pkg::WrapW-1:0]      wrap_page;
  logic [7:0]                      ring_size;
  logic [7:0]                      bnd_src;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_start_q <= rrhc_pkg::RingStartRst;
      ring_stop_q  <= rrhc_pkg::RingStopRst;
      count_fcs_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rrhc_pkg::CfgRingStart: ring_start_q <= cfg_data_i;
        rrhc_pkg::CfgRingStop:  ring_stop_q  <= cfg_data_i;
        rrhc_pkg::CfgCountFcs:  count_fcs_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Header checks on the captured request
  assign next_bad  = (req_q.next_page < ring_start_q) || (req_q.next_page >= ring_stop_q) ||
                     (req_q.next_page == req_q.read_page);
  assign count_bad = (space_q < rrhc_pkg::SpaceMin) || (space_q > rrhc_pkg::SpaceMax);
  assign rnd_space = space_q + rrhc_pkg::PageRnd;
  assign adv_page  = {1'b0, req_q.read_page} + {6'd0, rnd_space[10:8]};
  assign dlen_full = space_q - rrhc_pkg::SpaceOvh;
  assign ring_size = ring_stop_q - ring_start_q;

  rrhc_page_wrap u_wrap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (wrap_load),
    .page_i (adv_page),
    .stop_i (ring_stop_q),
    .size_i (ring_size),
    .done_o (wrap_done),
    .page_o (wrap_page)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    space_d   = space_q;
    verdict_d = verdict_q;
    dlen_d    = dlen_q;
    wrap_load = 1'b0;
    case (state_q)
      StIdle: begin
        if (start) begin
          space_d = {1'b0, req_i.byte_count} + (count_fcs_q ? '0 : rrhc_pkg::FcsAdd);
          state_d = StCheck;
        end
      end
      StCheck: begin
        dlen_d = '0;
        if (next_bad) begin
          verdict_d = rrhc_pkg::VerdictBadNext;
          state_d   = StDone;
        end else if (count_bad) begin
          verdict_d = rrhc_pkg::VerdictBadCnt;
          state_d   = StDone;
        end else begin
          wrap_load = 1'b1;
          state_d   = StWrap;
        end
      end
      StWrap: begin
        if (wrap_done) begin
          if (wrap_page != {1'b0, req_q.next_page}) begin
            verdict_d = rrhc_pkg::VerdictBadCnt;
          end else begin
            dlen_d    = dlen_full[rrhc_pkg::DlenW-1:0];
            verdict_d = |(req_q.rx_status & rrhc_pkg::StatusIntact) ?
                        rrhc_pkg::VerdictOk : rrhc_pkg::VerdictRxErr;
          end
          state_d = StDone;
        end
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the request and working values
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      req_q <= req_i;
    end
    space_q   <= space_d;
    verdict_q <= verdict_d;
    dlen_q    <= dlen_d;
  end

  // Result
  assign busy        = state_q != StIdle;
  assign res_valid_o = state_q == StDone;
  assign bnd_src     = (req_q.next_page == ring_start_q) ? ring_stop_q : req_q.next_page;

  always_comb begin
    res_o               = '0;
    res_o.verdict       = verdict_q;
    res_o.data_length   = dlen_q;
    res_o.boundary_page = bnd_src - 8'd1;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rrhc_page_wrap.sv =====
`default_nettype none

// Reduce a page number below the ring stop by repeated subtraction of the ring size
module rrhc_page_wrap (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       load_i,
  input  wire logic [rrhc_pkg::WrapW-1:0] page_i,
  input  wire logic [rrhc_pkg::PageW-1:0] stop_i,
  input  wire logic [rrhc_pkg::PageW-1:0] size_i,
  output logic                            done_o,
  output logic [rrhc_pkg::WrapW-1:0]      page_o
);

  logic                       run_q, run_d;
  logic [rrhc_pkg::WrapW-1:0] page_q, page_d;
  logic                       above;

  // Shared compare and subtract
  assign above  = page_q >= {1'b0, stop_i};
  assign done_o = run_q && !above;
  assign page_o = page_q;

  always_comb begin
    run_d  = run_q;
    page_d = page_q;
    if (load_i) begin
      run_d  = 1'b1;
      page_d = page_i;
    end else if (run_q) begin
      if (above) begin
        page_d = page_q - {1'b0, size_i};
      end else begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

`default_nettype wire
